/* rtl/fxalu_pkg.sv */
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Operation codes, default widths and shared types for the Q24.8 ALU.
// ----------------------------------------------------------------------------
package fxalu_pkg;

  localparam int unsigned FracBitsDef = 8;
  localparam int unsigned WordBitsDef = 32;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_TO_INT   = 4'd14,
    OP_FROM_INT = 4'd15
  } op_e;

  // Control that travels with a request down the divider cells.
  typedef struct packed {
    logic vld;
    logic is_div;
    logic dz;
    logic neg;
    logic flag;
  } ctl_t;

endpackage

/* rtl/fixed_point_q24_8_alu_unit.sv */
// ----------------------------------------------------------------------------
// Q24.8 fixed-point ALU
// Add, subtract, multiply, divide, compare, min/max, step and integer
// conversion on signed fixed-point words, one request per cycle.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+-------------------------------
//  request   | in        | start_i, busy_o    | kind_i, operand_a_i, operand_b_i
//  result    | out       | done_o (strobe)    | value_o, flag_o, div_zero_o
//
// A request is taken on any edge where start_i is high; busy_o is always low.
// Every request, whatever its code, leaves through one chain of
// WORD_BITS+FRAC_WIDTH+2 registered stages: an entry stage, one divider cell
// per quotient bit and an output stage, so order is kept. The depth is set
// by the bit-serial divider chain. Reset clears the valid bits of every
// stage; the receiver cannot stall, results are strobed once.
module fixed_point_q24_8_alu_unit #(
  parameter int unsigned FRAC_WIDTH = fxalu_pkg::FracBitsDef,
  parameter int unsigned WORD_BITS  = fxalu_pkg::WordBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [3:0]         kind_i,
  input  logic signed [31:0] operand_a_i,
  input  logic signed [31:0] operand_b_i,
  output logic               done_o,
  output logic signed [31:0] value_o,
  output logic               flag_o,
  output logic               div_zero_o
);

  localparam int unsigned W     = WORD_BITS;
  localparam int unsigned NBits = WORD_BITS + FRAC_WIDTH;
  localparam int unsigned Cells = NBits;

  assign busy_o = 1'b0;

  // Operands reduced to the working word width.
  logic signed [W-1:0]   a_w, b_w;
  logic signed [2*W-1:0] prod;
  logic [W-1:0]          val_d;
  logic                  flag_d;
  logic                  is_div;
  logic [W-1:0]          a_mag, b_mag;
  logic [NBits-1:0]      num_d;
  fxalu_pkg::op_e        op;

  assign a_w   = operand_a_i[W-1:0];
  assign b_w   = operand_b_i[W-1:0];
  assign op    = fxalu_pkg::op_e'(kind_i);
  assign prod  = W'(0) + (2*W)'(a_w) * (2*W)'(b_w);
  assign a_mag = a_w[W-1] ? W'(-a_w) : W'(a_w);
  assign b_mag = b_w[W-1] ? W'(-b_w) : W'(b_w);
  assign num_d = {a_mag, {FRAC_WIDTH{1'b0}}};
  assign is_div = (op == fxalu_pkg::OP_DIV);

  // Everything but the quotient is settled at the entry; the quotient is
  // built by the cells and picked at the end.
  always_comb begin
    val_d  = '0;
    flag_d = 1'b0;
    case (op)
      fxalu_pkg::OP_ADD:      val_d = W'(a_w + b_w);
      fxalu_pkg::OP_SUB:      val_d = W'(a_w - b_w);
      fxalu_pkg::OP_MUL:      val_d = prod[FRAC_WIDTH +: W];
      fxalu_pkg::OP_DIV:      val_d = '0;
      fxalu_pkg::OP_GT:       flag_d = (a_w > b_w);
      fxalu_pkg::OP_LT:       flag_d = (a_w < b_w);
      fxalu_pkg::OP_GE:       flag_d = (a_w >= b_w);
      fxalu_pkg::OP_LE:       flag_d = (a_w <= b_w);
      fxalu_pkg::OP_EQ:       flag_d = (a_w == b_w);
      fxalu_pkg::OP_NE:       flag_d = (a_w != b_w);
      fxalu_pkg::OP_MIN:      val_d = (a_w < b_w) ? a_w : b_w;
      fxalu_pkg::OP_MAX:      val_d = (a_w > b_w) ? a_w : b_w;
      fxalu_pkg::OP_INC:      val_d = W'(a_w + W'(1));
      fxalu_pkg::OP_DEC:      val_d = W'(a_w - W'(1));
      fxalu_pkg::OP_TO_INT:   val_d = W'(a_w >>> FRAC_WIDTH);
      fxalu_pkg::OP_FROM_INT: val_d = W'(a_w << FRAC_WIDTH);
      default:                val_d = '0;
    endcase
  end

  // Entry stage.
  fxalu_pkg::ctl_t  ctl_q;
  logic [NBits-1:0] num_q;
  logic [W-1:0]     den_q;
  logic [W-1:0]     val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q.vld    <= start_i;
      ctl_q.is_div <= is_div;
      ctl_q.dz     <= is_div && (b_w == '0);
      ctl_q.neg    <= a_w[W-1] ^ b_w[W-1];
      ctl_q.flag   <= flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= b_mag;
    val_q <= val_d;
  end

  // Divider chain: one quotient bit per cell.
  fxalu_pkg::ctl_t  ctl_c [Cells+1];
  logic [NBits-1:0] num_c [Cells+1];
  logic [W-1:0]     den_c [Cells+1];
  logic [W:0]       rem_c [Cells+1];
  logic [W-1:0]     val_c [Cells+1];

  assign ctl_c[0] = ctl_q;
  assign num_c[0] = num_q;
  assign den_c[0] = den_q;
  assign rem_c[0] = '0;
  assign val_c[0] = val_q;

  for (genvar g = 0; g < Cells; g++) begin : g_cell
    fxalu_cell #(
      .NumBits (NBits),
      .DenBits (W),
      .WordBits(W)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (ctl_c[g]),
      .num_i (num_c[g]),
      .den_i (den_c[g]),
      .rem_i (rem_c[g]),
      .val_i (val_c[g]),
      .ctl_o (ctl_c[g+1]),
      .num_o (num_c[g+1]),
      .den_o (den_c[g+1]),
      .rem_o (rem_c[g+1]),
      .val_o (val_c[g+1])
    );
  end

  // Output stage: sign the quotient, wrap to the word and extend to 32 bits.
  fxalu_pkg::ctl_t ctl_end;
  logic [W-1:0]    quo;
  logic [W-1:0]    res_w;
  logic            done_q;
  logic [31:0]     value_q;
  logic            flag_q, dz_q;

  assign ctl_end = ctl_c[Cells];
  assign quo     = num_c[Cells][W-1:0];

  always_comb begin
    if (!ctl_end.is_div) begin
      res_w = val_c[Cells];
    end else if (ctl_end.dz) begin
      res_w = '0;
    end else begin
      res_w = ctl_end.neg ? W'(-quo) : quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_end.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= 32'(signed'(res_w));
    flag_q  <= ctl_end.flag;
    dz_q    <= ctl_end.dz;
  end

  assign done_o     = done_q;
  assign value_o    = value_q;
  assign flag_o     = flag_q;
  assign div_zero_o = dz_q;

  // A division by zero is flagged only for divide requests.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q.dz |-> ctl_q.is_div)
    else $error("div_zero marked on a non-divide request");

  // A request valid at the end of the divider chain is registered into the done_o strobe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_c[Cells].vld |=> done_o)
    else $error("result lost at the chain output");

  // Comparison flag and divide-by-zero never appear together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(flag_o && div_zero_o))
    else $error("flag and div_zero both set");

endmodule

/* rtl/fxalu_cell.sv */
// ----------------------------------------------------------------------------
// Fixed-point ALU divider cell
// One restoring-division step on a magnitude, registered toward the next cell.
// ----------------------------------------------------------------------------
module fxalu_cell #(
  parameter int unsigned NumBits = 40,
  parameter int unsigned DenBits = 32,
  parameter int unsigned WordBits = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fxalu_pkg::ctl_t     ctl_i,
  input  logic [NumBits-1:0]  num_i,
  input  logic [DenBits-1:0]  den_i,
  input  logic [DenBits:0]    rem_i,
  input  logic [WordBits-1:0] val_i,
  output fxalu_pkg::ctl_t     ctl_o,
  output logic [NumBits-1:0]  num_o,
  output logic [DenBits-1:0]  den_o,
  output logic [DenBits:0]    rem_o,
  output logic [WordBits-1:0] val_o
);

  logic [DenBits:0]    shifted;
  logic [DenBits+1:0]  diff;
  logic                fits;
  fxalu_pkg::ctl_t     ctl_q;
  logic [NumBits-1:0]  num_q;
  logic [DenBits-1:0]  den_q;
  logic [DenBits:0]    rem_q;
  logic [WordBits-1:0] val_q;

  // Bring down the next dividend bit and try to subtract the divisor.
  assign shifted = {rem_i[DenBits-1:0], num_i[NumBits-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_i};
  assign fits    = ~diff[DenBits+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= {num_i[NumBits-2:0], fits};
    den_q <= den_i;
    rem_q <= fits ? diff[DenBits:0] : shifted;
    val_q <= val_i;
  end

  assign ctl_o = ctl_q;
  assign num_o = num_q;
  assign den_o = den_q;
  assign rem_o = rem_q;
  assign val_o = val_q;

endmodule
